[hdl/srsw_pkg.sv]
// Shared types and constants for the selective-repeat sender window.
// Used by srsw_regs, srsw_ctrl, srsw_dp and the top level; depends on nothing.
package srsw_pkg;

    localparam int unsigned SLOTS       = 32;
    localparam int unsigned SLOT_W      = 5;
    localparam int unsigned SEG_PAYLOAD = 1024;
    localparam int unsigned SEG_SHIFT   = 10;
    localparam int unsigned SEG_W       = 11;
    localparam int unsigned APB_ADDR_W  = 5;
    localparam int unsigned RAM_W       = SEG_W + 32;

    localparam logic [2:0] REG_WINDOW_LIMIT = 3'd0;
    localparam logic [2:0] REG_TIMEOUT      = 3'd1;
    localparam logic [2:0] REG_CONNECTION   = 3'd2;
    localparam logic [2:0] REG_PROTOCOL     = 3'd3;
    localparam logic [2:0] REG_ACK_TYPE     = 3'd4;

    localparam logic [5:0]  RST_WINDOW_LIMIT = 6'd9;
    localparam logic [15:0] RST_TIMEOUT      = 16'd67;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_SEND   = 2'd0,
        KIND_RETX   = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_ACK    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_REJECT,
        ST_SEND,
        ST_SLIDE,
        ST_ACK_OUT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_END
    } t_state;

    typedef struct packed {
        logic [5:0]  window_limit;
        logic [15:0] timeout;
        logic [15:0] connection;
        logic [7:0]  protocol;
        logic [7:0]  ack_type;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic ack_mark;
        logic slide_step;
        logic emit_reject;
        logic emit_ack;
        logic send_seg;
        logic scan_start;
        logic scan_rd;
        logic scan_skip;
        logic scan_take;
        logic scan_flush;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic len_zero;
        logic reject;
        logic seg_last;
        logic slide_ok;
        logic scan_done;
        logic due;
        logic pend_valid;
        logic out_free;
    } t_stat;

endpackage

[hdl/srsw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srsw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/srsw_regs.sv]
// APB configuration registers of the sender window.
// Depends on srsw_pkg.
module srsw_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srsw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output srsw_pkg::t_cfg                  o_cfg
);

    srsw_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_limit <= srsw_pkg::RST_WINDOW_LIMIT;
            r_cfg.timeout      <= srsw_pkg::RST_TIMEOUT;
            r_cfg.connection   <= '0;
            r_cfg.protocol     <= '0;
            r_cfg.ack_type     <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                srsw_pkg::REG_WINDOW_LIMIT: r_cfg.window_limit <= pwdata[5:0];
                srsw_pkg::REG_TIMEOUT:      r_cfg.timeout      <= pwdata[15:0];
                srsw_pkg::REG_CONNECTION:   r_cfg.connection   <= pwdata[15:0];
                srsw_pkg::REG_PROTOCOL:     r_cfg.protocol     <= pwdata[7:0];
                srsw_pkg::REG_ACK_TYPE:     r_cfg.ack_type     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            srsw_pkg::REG_WINDOW_LIMIT: prdata = {26'd0, r_cfg.window_limit};
            srsw_pkg::REG_TIMEOUT:      prdata = {16'd0, r_cfg.timeout};
            srsw_pkg::REG_CONNECTION:   prdata = {16'd0, r_cfg.connection};
            srsw_pkg::REG_PROTOCOL:     prdata = {24'd0, r_cfg.protocol};
            srsw_pkg::REG_ACK_TYPE:     prdata = {24'd0, r_cfg.ack_type};
            default:                    prdata = '0;
        endcase
    end

endmodule

[hdl/srsw_ctrl.sv]
// Controller state machine: sequences send, ack slide and timer scan.
// Depends on srsw_pkg; drives srsw_dp through t_cmd, reads t_stat.
module srsw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  srsw_pkg::t_stat i_stat,
    output srsw_pkg::t_cmd  o_cmd
);

    srsw_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srsw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srsw_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = srsw_pkg::ST_DECODE;
            end
            srsw_pkg::ST_DECODE: begin
                unique case (i_stat.op)
                    srsw_pkg::OP_SEND: begin
                        priority if (i_stat.len_zero) n_state = srsw_pkg::ST_IDLE;
                        else if (i_stat.reject)       n_state = srsw_pkg::ST_REJECT;
                        else                          n_state = srsw_pkg::ST_SEND;
                    end
                    srsw_pkg::OP_ACK:  n_state = srsw_pkg::ST_SLIDE;
                    srsw_pkg::OP_TICK: n_state = srsw_pkg::ST_SCAN_RD;
                    default:           n_state = srsw_pkg::ST_IDLE;
                endcase
            end
            srsw_pkg::ST_REJECT: begin
                if (i_stat.out_free) n_state = srsw_pkg::ST_IDLE;
            end
            srsw_pkg::ST_SEND: begin
                if (i_stat.out_free && i_stat.seg_last) n_state = srsw_pkg::ST_IDLE;
            end
            srsw_pkg::ST_SLIDE: begin
                if (!i_stat.slide_ok) n_state = srsw_pkg::ST_ACK_OUT;
            end
            srsw_pkg::ST_ACK_OUT: begin
                if (i_stat.out_free) n_state = srsw_pkg::ST_IDLE;
            end
            srsw_pkg::ST_SCAN_RD: begin
                if (i_stat.scan_done) n_state = srsw_pkg::ST_SCAN_END;
                else                  n_state = srsw_pkg::ST_SCAN_CHK;
            end
            srsw_pkg::ST_SCAN_CHK: begin
                if (!i_stat.due || !i_stat.pend_valid || i_stat.out_free)
                    n_state = srsw_pkg::ST_SCAN_RD;
            end
            srsw_pkg::ST_SCAN_END: begin
                if (!i_stat.pend_valid || i_stat.out_free) n_state = srsw_pkg::ST_IDLE;
            end
            default: n_state = srsw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            srsw_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            srsw_pkg::ST_DECODE: begin
                o_cmd.ack_mark   = (i_stat.op == srsw_pkg::OP_ACK);
                o_cmd.scan_start = (i_stat.op == srsw_pkg::OP_TICK);
            end
            srsw_pkg::ST_REJECT:   o_cmd.emit_reject = i_stat.out_free;
            srsw_pkg::ST_SEND:     o_cmd.send_seg    = i_stat.out_free;
            srsw_pkg::ST_SLIDE:    o_cmd.slide_step  = i_stat.slide_ok;
            srsw_pkg::ST_ACK_OUT:  o_cmd.emit_ack    = i_stat.out_free;
            srsw_pkg::ST_SCAN_RD:  o_cmd.scan_rd     = !i_stat.scan_done;
            srsw_pkg::ST_SCAN_CHK: begin
                o_cmd.scan_skip = !i_stat.due;
                o_cmd.scan_take = i_stat.due && (!i_stat.pend_valid || i_stat.out_free);
            end
            srsw_pkg::ST_SCAN_END: o_cmd.scan_flush = i_stat.pend_valid && i_stat.out_free;
            default: ;
        endcase
    end

endmodule

[hdl/srsw_dp.sv]
// Datapath: window pointers, slot flags, slot RAM and the output register.
// Depends on srsw_pkg and srsw_ram; commanded by srsw_ctrl.
module srsw_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  srsw_pkg::t_cfg             i_cfg,
    input  srsw_pkg::t_cmd             i_cmd,
    output srsw_pkg::t_stat            o_stat,
    input  logic [1:0]                 i_in_user,
    input  logic [111:0]               i_in_data,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [1:0]                 o_out_kind,
    output logic [63:0]                o_out_data,
    output logic                       o_out_last
);

    localparam int unsigned SW = srsw_pkg::SLOT_W;
    localparam int unsigned LW = srsw_pkg::SEG_W;

    // latched item
    srsw_pkg::t_op r_op;
    logic [15:0]   r_len;
    logic [31:0]   r_now;
    logic [7:0]    r_aproto, r_atype;
    logic [15:0]   r_aconn, r_aseq, r_apwin;

    logic [15:0]   r_base, r_next, r_pwin, r_done;
    logic [srsw_pkg::SLOTS-1:0] r_used, r_acked;

    logic [5:0]    r_scan_i;
    logic [15:0]   r_scan_seq;
    logic          r_pend_valid;
    logic [15:0]   r_pend_seq;
    logic [LW-1:0] r_pend_len;

    logic              r_out_valid, r_out_last;
    srsw_pkg::t_kind   r_out_kind;
    logic [15:0]       r_out_seq, r_out_off, r_out_pwin;
    logic [SW-1:0]     r_out_slot;
    logic [LW-1:0]     r_out_bytes;

    logic [15:0]   w_fl, w_lim, w_need, w_remain, w_ack_dist, w_scan_seq;
    logic [16:0]   w_need_sum;
    logic [5:0]    w_lim6;
    logic [LW-1:0] w_size;
    logic          w_out_free, w_match, w_due;
    logic [SW-1:0] w_base_slot, w_ack_slot, w_next_slot, w_scan_slot;
    logic [srsw_pkg::RAM_W-1:0] w_rdata, w_wdata;
    logic [SW-1:0] w_waddr;
    logic          w_we;
    logic [31:0]   w_age;

    assign w_fl        = r_next - r_base;
    assign w_lim6      = (i_cfg.window_limit > 6'(srsw_pkg::SLOTS)) ?
                         6'(srsw_pkg::SLOTS) : i_cfg.window_limit;
    assign w_lim       = {10'd0, w_lim6};
    assign w_need_sum  = {1'b0, r_len} + 17'(srsw_pkg::SEG_PAYLOAD - 1);
    assign w_need      = 16'(w_need_sum >> srsw_pkg::SEG_SHIFT);
    assign w_remain    = r_len - r_done;
    assign w_size      = (w_remain > 16'(srsw_pkg::SEG_PAYLOAD)) ?
                         LW'(srsw_pkg::SEG_PAYLOAD) : w_remain[LW-1:0];
    assign w_base_slot = r_base[SW-1:0];
    assign w_next_slot = r_next[SW-1:0];
    assign w_ack_slot  = r_aseq[SW-1:0];
    assign w_ack_dist  = r_aseq - r_base;
    assign w_match     = (r_aproto == i_cfg.protocol) && (r_atype == i_cfg.ack_type) &&
                         (r_aconn == i_cfg.connection);
    assign w_scan_seq  = r_base + {10'd0, r_scan_i};
    assign w_scan_slot = r_scan_seq[SW-1:0];
    assign w_age       = r_now - w_rdata[31:0];
    assign w_due       = r_used[w_scan_slot] && !r_acked[w_scan_slot] &&
                         (w_age >= {16'd0, i_cfg.timeout});
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.op         = r_op;
        o_stat.len_zero   = (r_len == 16'd0);
        o_stat.reject     = (w_fl > w_lim) || ((w_lim - w_fl) < w_need);
        o_stat.seg_last   = (w_remain <= 16'(srsw_pkg::SEG_PAYLOAD));
        o_stat.slide_ok   = (r_base != r_next) && r_used[w_base_slot] && r_acked[w_base_slot];
        o_stat.scan_done  = ({10'd0, r_scan_i} == w_fl);
        o_stat.due        = w_due;
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = w_out_free;
    end

    // slot RAM holds {length, send stamp}; in-flight slots map uniquely to sequences
    always_comb begin
        w_we    = i_cmd.send_seg || i_cmd.scan_take;
        w_waddr = i_cmd.send_seg ? w_next_slot : w_scan_slot;
        w_wdata = i_cmd.send_seg ? {w_size, r_now} : {w_rdata[srsw_pkg::RAM_W-1:32], r_now};
    end

    srsw_ram #(
        .WIDTH (srsw_pkg::RAM_W),
        .DEPTH (srsw_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (w_scan_seq[SW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= srsw_pkg::t_op'(i_in_user);
            r_len    <= i_in_data[15:0];
            r_now    <= i_in_data[47:16];
            r_aproto <= i_in_data[55:48];
            r_atype  <= i_in_data[63:56];
            r_aconn  <= i_in_data[79:64];
            r_aseq   <= i_in_data[95:80];
            r_apwin  <= i_in_data[111:96];
            r_done   <= '0;
        end else if (i_cmd.send_seg) begin
            r_done <= r_done + {5'd0, w_size};
        end
        if (i_cmd.scan_rd) begin
            r_scan_seq <= w_scan_seq;
        end
        if (i_cmd.scan_take) begin
            r_pend_seq <= r_scan_seq;
            r_pend_len <= w_rdata[srsw_pkg::RAM_W-1:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_next       <= '0;
            r_pwin       <= '0;
            r_used       <= '0;
            r_acked      <= '0;
            r_scan_i     <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.ack_mark && w_match) begin
                r_pwin <= r_apwin;
                if (r_used[w_ack_slot] && (w_ack_dist < w_fl)) r_acked[w_ack_slot] <= 1'b1;
            end
            if (i_cmd.slide_step) begin
                r_used[w_base_slot]  <= 1'b0;
                r_acked[w_base_slot] <= 1'b0;
                r_base               <= r_base + 16'd1;
            end
            if (i_cmd.send_seg) begin
                r_used[w_next_slot]  <= 1'b1;
                r_acked[w_next_slot] <= 1'b0;
                r_next               <= r_next + 16'd1;
            end
            if (i_cmd.scan_start) begin
                r_scan_i     <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.scan_skip || i_cmd.scan_take) r_scan_i <= r_scan_i + 6'd1;
            if (i_cmd.scan_take)  r_pend_valid <= 1'b1;
            if (i_cmd.scan_flush) r_pend_valid <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_reject || i_cmd.emit_ack || i_cmd.send_seg ||
                     i_cmd.scan_flush || (i_cmd.scan_take && r_pend_valid)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_reject) begin
            r_out_kind  <= srsw_pkg::KIND_REJECT;
            r_out_seq   <= r_next;
            r_out_slot  <= '0;
            r_out_bytes <= '0;
            r_out_off   <= '0;
            r_out_pwin  <= r_pwin;
            r_out_last  <= 1'b1;
        end else if (i_cmd.emit_ack) begin
            r_out_kind  <= srsw_pkg::KIND_ACK;
            r_out_seq   <= r_base;
            r_out_slot  <= '0;
            r_out_bytes <= '0;
            r_out_off   <= '0;
            r_out_pwin  <= r_pwin;
            r_out_last  <= 1'b1;
        end else if (i_cmd.send_seg) begin
            r_out_kind  <= srsw_pkg::KIND_SEND;
            r_out_seq   <= r_next;
            r_out_slot  <= w_next_slot;
            r_out_bytes <= w_size;
            r_out_off   <= r_done;
            r_out_pwin  <= r_pwin;
            r_out_last  <= (w_remain <= 16'(srsw_pkg::SEG_PAYLOAD));
        end else if (i_cmd.scan_flush || (i_cmd.scan_take && r_pend_valid)) begin
            r_out_kind  <= srsw_pkg::KIND_RETX;
            r_out_seq   <= r_pend_seq;
            r_out_slot  <= r_pend_seq[SW-1:0];
            r_out_bytes <= r_pend_len;
            r_out_off   <= '0;
            r_out_pwin  <= r_pwin;
            r_out_last  <= i_cmd.scan_flush;
        end else begin
            r_out_kind  <= r_out_kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {r_out_pwin, r_out_off, r_out_bytes, r_out_slot, r_out_seq};

endmodule

[hdl/selective_repeat_sender_window.sv]
// Top level of the selective-repeat sender window for one connection.
// Depends on srsw_pkg, srsw_regs, srsw_ctrl, srsw_dp (which holds srsw_ram).
//
// Usage: items enter on the s_axis channel; tuser selects send request,
// acknowledgement or timer tick. Results leave on m_axis, tlast marking the
// final result of an item. Configuration goes through the APB port.
// One item is worked at a time; s_axis_tready is high only when idle.
// A send yields its first segment after the decode state, then one segment
// per cycle while the output register is free. An ack slides the window over
// each acknowledged slot at its base (up to 32). A tick scans each in-flight
// slot (up to 32) in a read state and a check state, the slot RAM read being
// registered; a retransmit is held one slot back so tlast can be set on the
// last one. Reset clears pointers, slot flags, the stored peer window and
// restores register defaults; no RAM clearing pass is needed.
// When m_axis_tready is low the single output register holds its result and
// the sequencer waits; no result is lost or repeated.
module selective_repeat_sender_window (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: send_length[15:0], now_ms[47:16], ack_protocol[55:48], ack_type[63:56],
    //        ack_connection[79:64], ack_sequence[95:80], ack_peer_window[111:96]
    input  logic [111:0]                    s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: sequence_number[15:0], slot_index[20:16], segment_bytes[31:21],
    //        buffer_offset[47:32], peer_window[63:48]
    output logic [63:0]                     m_axis_tdata,
    // tuser: result_kind[1:0]
    output logic [1:0]                      m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srsw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    srsw_pkg::t_cfg  w_cfg;
    srsw_pkg::t_cmd  w_cmd;
    srsw_pkg::t_stat w_stat;

    srsw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    srsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    srsw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_user   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
